// ----- rtl/core/dlfb_pkg.sv -----
// Shared constants, types and helpers of the dense layer forward/backward block.
package dlfb_pkg;

  localparam int MAX_IN    = 16;
  localparam int MAX_OUT   = 16;
  localparam int MAX_BATCH = 8;

  localparam int IDX_W  = 4;
  localparam int SMP_W  = 3;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;
  localparam int SZ_W   = 5;
  localparam int BS_W   = 4;
  localparam int DIV_W  = 43;
  localparam int CNT_W  = 6;

  localparam int W_DEPTH = MAX_OUT * MAX_IN;
  localparam int X_DEPTH = MAX_BATCH * MAX_IN;

  localparam logic [2:0] CMD_WR_W = 3'd0;
  localparam logic [2:0] CMD_WR_B = 3'd1;
  localparam logic [2:0] CMD_FWD  = 3'd2;
  localparam logic [2:0] CMD_BWD  = 3'd3;
  localparam logic [2:0] CMD_RD_W = 3'd4;
  localparam logic [2:0] CMD_RD_B = 3'd5;

  localparam logic [1:0] KIND_FWD = 2'd0;
  localparam logic [1:0] KIND_DX  = 2'd1;
  localparam logic [1:0] KIND_WG  = 2'd2;
  localparam logic [1:0] KIND_BG  = 2'd3;

  typedef enum logic [2:0] {OP_FWD, OP_BWD, OP_WGR, OP_RDW, OP_RDB} op_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic [SMP_W-1:0] smp;
    logic             first;
    logic             last;
    logic             lastrun;
    logic             bupd;
    logic             zero;
    logic [IDX_W-1:0] idx;
    logic             wr_w;
    logic             wr_b;
    logic             wr_x;
    logic             wr_g;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } dp_sts_t;

  localparam logic signed [DIV_W-1:0] SAT_HI = 32767;
  localparam logic signed [DIV_W-1:0] SAT_LO = -32768;

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [DIV_W-1:0] v);
    logic signed [DIV_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[VAL_W-1:0];
  endfunction

endpackage

// ----- rtl/core/dlfb_ctrl.sv -----
// Sequencer of the dense layer: decodes commands and walks the product loops.
module dlfb_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [2:0]               in_cmd,
  input  logic [3:0]               in_row,
  input  logic [3:0]               in_col,
  input  logic [2:0]               in_sample,
  input  logic [dlfb_pkg::SZ_W-1:0] in_size,
  input  logic [dlfb_pkg::SZ_W-1:0] out_size,
  input  dlfb_pkg::dp_sts_t        sts,
  output logic                     busy,
  output dlfb_pkg::dp_cmd_t        cmd
);

  typedef enum logic [2:0] {S_IDLE, S_FWD, S_BWD, S_WGR, S_READ, S_DIV, S_DRAIN} state_t;

  state_t state_r, state_nxt;
  logic [3:0] o_r, o_nxt, i_r, i_nxt;
  logic [2:0] smp_r, smp_nxt;
  logic [3:0] rd_j_r, rd_j_nxt, rd_k_r, rd_k_nxt;
  logic       rd_zero_r, rd_zero_nxt;
  dlfb_pkg::op_t rd_op_r, rd_op_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic       busy_r, busy_nxt;

  logic [dlfb_pkg::SZ_W-1:0] ni, no, ni_m1w, no_m1w;
  logic [3:0] ni_m1, no_m1;
  logic accept;

  // Sizes of zero act as one and sizes beyond the array act as its depth.
  always_comb begin
    ni = in_size;
    if (in_size == '0) ni = dlfb_pkg::SZ_W'(1);
    else if (in_size > dlfb_pkg::SZ_W'(dlfb_pkg::MAX_IN)) ni = dlfb_pkg::SZ_W'(dlfb_pkg::MAX_IN);
    no = out_size;
    if (out_size == '0) no = dlfb_pkg::SZ_W'(1);
    else if (out_size > dlfb_pkg::SZ_W'(dlfb_pkg::MAX_OUT)) no = dlfb_pkg::SZ_W'(dlfb_pkg::MAX_OUT);
  end

  assign ni_m1w = ni - dlfb_pkg::SZ_W'(1);
  assign no_m1w = no - dlfb_pkg::SZ_W'(1);
  assign ni_m1  = ni_m1w[3:0];
  assign no_m1  = no_m1w[3:0];
  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    state_nxt   = state_r;
    o_nxt       = o_r;
    i_nxt       = i_r;
    smp_nxt     = smp_r;
    rd_j_nxt    = rd_j_r;
    rd_k_nxt    = rd_k_r;
    rd_zero_nxt = rd_zero_r;
    rd_op_nxt   = rd_op_r;
    drain_nxt   = drain_r;
    cmd         = '0;
    cmd.op      = dlfb_pkg::OP_FWD;
    cmd.smp     = smp_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            dlfb_pkg::CMD_WR_W: cmd.wr_w = 1'b1;
            dlfb_pkg::CMD_WR_B: cmd.wr_b = 1'b1;
            dlfb_pkg::CMD_FWD: begin
              if ({1'b0, in_col} < ni) begin
                cmd.wr_x = 1'b1;
                if (in_col == ni_m1) begin
                  state_nxt = S_FWD;
                  o_nxt     = '0;
                  i_nxt     = '0;
                  smp_nxt   = in_sample;
                end
              end
            end
            dlfb_pkg::CMD_BWD: begin
              if ({1'b0, in_row} < no) begin
                cmd.wr_g = 1'b1;
                if (in_row == no_m1) begin
                  state_nxt = S_BWD;
                  o_nxt     = '0;
                  i_nxt     = '0;
                  smp_nxt   = in_sample;
                end
              end
            end
            dlfb_pkg::CMD_RD_W: begin
              state_nxt   = S_READ;
              rd_op_nxt   = dlfb_pkg::OP_RDW;
              rd_j_nxt    = in_row;
              rd_k_nxt    = in_col;
              rd_zero_nxt = !(({1'b0, in_row} < no) && ({1'b0, in_col} < ni));
            end
            dlfb_pkg::CMD_RD_B: begin
              state_nxt   = S_READ;
              rd_op_nxt   = dlfb_pkg::OP_RDB;
              rd_j_nxt    = in_row;
              rd_k_nxt    = in_row;
              rd_zero_nxt = !({1'b0, in_row} < no);
            end
            default: ;
          endcase
        end
      end
      S_FWD: begin
        cmd.valid   = 1'b1;
        cmd.op      = dlfb_pkg::OP_FWD;
        cmd.j       = o_r;
        cmd.k       = i_r;
        cmd.idx     = o_r;
        cmd.first   = (i_r == '0);
        cmd.last    = (i_r == ni_m1);
        cmd.lastrun = (o_r == no_m1);
        if (i_r == ni_m1) begin
          i_nxt = '0;
          if (o_r == no_m1) begin
            state_nxt = S_DRAIN;
            drain_nxt = 2'd2;
          end else begin
            o_nxt = o_r + 4'd1;
          end
        end else begin
          i_nxt = i_r + 4'd1;
        end
      end
      S_BWD: begin
        cmd.valid   = 1'b1;
        cmd.op      = dlfb_pkg::OP_BWD;
        cmd.j       = i_r;
        cmd.k       = o_r;
        cmd.idx     = o_r;
        cmd.first   = (i_r == '0);
        cmd.last    = (i_r == no_m1);
        cmd.lastrun = (o_r == ni_m1);
        if (i_r == no_m1) begin
          i_nxt = '0;
          if (o_r == ni_m1) begin
            state_nxt = S_WGR;
            o_nxt     = '0;
          end else begin
            o_nxt = o_r + 4'd1;
          end
        end else begin
          i_nxt = i_r + 4'd1;
        end
      end
      S_WGR: begin
        cmd.valid = 1'b1;
        cmd.op    = dlfb_pkg::OP_WGR;
        cmd.j     = o_r;
        cmd.k     = i_r;
        cmd.bupd  = (i_r == '0);
        if (i_r == ni_m1) begin
          i_nxt = '0;
          if (o_r == no_m1) begin
            state_nxt = S_DRAIN;
            drain_nxt = 2'd2;
          end else begin
            o_nxt = o_r + 4'd1;
          end
        end else begin
          i_nxt = i_r + 4'd1;
        end
      end
      S_READ: begin
        cmd.valid   = 1'b1;
        cmd.op      = rd_op_r;
        cmd.j       = rd_j_r;
        cmd.k       = rd_k_r;
        cmd.idx     = rd_k_r;
        cmd.zero    = rd_zero_r;
        cmd.last    = 1'b1;
        cmd.lastrun = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_IDLE;
      end
      S_DRAIN: begin
        if (drain_r == '0) state_nxt = S_IDLE;
        else drain_nxt = drain_r - 2'd1;
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      drain_r <= drain_nxt;
    end
    o_r       <= o_nxt;
    i_r       <= i_nxt;
    smp_r     <= smp_nxt;
    rd_j_r    <= rd_j_nxt;
    rd_k_r    <= rd_k_nxt;
    rd_zero_r <= rd_zero_nxt;
    rd_op_r   <= rd_op_nxt;
  end

endmodule

// ----- rtl/core/dlfb_datapath.sv -----
// Stores, shared multiply-accumulate pipeline, gradient divider and result register.
module dlfb_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dlfb_pkg::dp_cmd_t         cmd,
  output dlfb_pkg::dp_sts_t         sts,
  input  logic [3:0]                in_row,
  input  logic [3:0]                in_col,
  input  logic [2:0]                in_sample,
  input  logic signed [15:0]        in_value,
  input  logic [dlfb_pkg::BS_W-1:0] batch_size,
  output logic                      out_valid,
  output logic [1:0]                out_kind,
  output logic [3:0]                out_index,
  output logic signed [15:0]        out_result_value,
  output logic                      out_last
);

  logic signed [15:0] w_mem    [dlfb_pkg::W_DEPTH];
  logic signed [15:0] x_mem    [dlfb_pkg::X_DEPTH];
  logic signed [39:0] wacc_mem [dlfb_pkg::W_DEPTH];
  logic signed [15:0] bias_q   [dlfb_pkg::MAX_OUT];
  logic signed [15:0] grad_q   [dlfb_pkg::MAX_OUT];
  logic signed [39:0] bacc_q   [dlfb_pkg::MAX_OUT];

  dlfb_pkg::dp_cmd_t tag1_r, tag2_r;
  logic signed [15:0] wd_r, xd_r, gd_r, bd_r, bias2_r;
  logic signed [39:0] waccd_r, baccd_r, waccd2_r, acc_r;
  logic signed [31:0] prod_r;
  logic signed [15:0] opa, opb;
  logic signed [39:0] prod_ext, wsum, acc_base, g_ext;

  logic       emit_r, em_last_r;
  logic [1:0] em_kind_r;
  logic [3:0] em_idx_r;

  logic       div_run_r, div_neg_r, div_last_r;
  logic [1:0] div_kind_r;
  logic [3:0] div_idx_r;
  logic [dlfb_pkg::DIV_W-1:0] div_q_r;
  logic [3:0] div_rem_r;
  logic [dlfb_pkg::CNT_W-1:0] div_cnt_r;
  logic [dlfb_pkg::BS_W-1:0] bs;

  logic       out_valid_r, out_last_r;
  logic [1:0] out_kind_r;
  logic [3:0] out_index_r;
  logic signed [15:0] out_value_r;

  // Stores: weight, input and weight-gradient memories, small register files.
  always_ff @(posedge clk) begin
    if (cmd.wr_w) w_mem[{in_row, in_col}] <= in_value;
    wd_r <= w_mem[{cmd.j, cmd.k}];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_x) x_mem[{in_sample, in_col}] <= in_value;
    xd_r <= x_mem[{cmd.smp, cmd.k}];
  end

  assign prod_ext = {{8{prod_r[31]}}, prod_r};
  assign wsum     = (tag2_r.smp == '0) ? prod_ext : waccd2_r + prod_ext;

  always_ff @(posedge clk) begin
    if (tag2_r.valid && tag2_r.op == dlfb_pkg::OP_WGR) wacc_mem[{tag2_r.j, tag2_r.k}] <= wsum;
    waccd_r <= wacc_mem[{cmd.j, cmd.k}];
  end

  assign g_ext = {{24{grad_q[cmd.j][15]}}, grad_q[cmd.j]};

  always_ff @(posedge clk) begin
    if (cmd.wr_b) bias_q[in_row] <= in_value;
    if (cmd.wr_g) grad_q[in_row] <= in_value;
    if (cmd.valid && cmd.bupd) begin
      bacc_q[cmd.j] <= (cmd.smp == '0) ? g_ext : bacc_q[cmd.j] + g_ext;
    end
    bd_r    <= bias_q[cmd.j];
    gd_r    <= grad_q[cmd.j];
    baccd_r <= bacc_q[cmd.j];
  end

  // Multiplier operands follow the operation carried by the stage tag.
  always_comb begin
    case (tag1_r.op)
      dlfb_pkg::OP_BWD: begin opa = gd_r; opb = wd_r; end
      dlfb_pkg::OP_WGR: begin opa = gd_r; opb = xd_r; end
      default:          begin opa = xd_r; opb = wd_r; end
    endcase
  end

  assign acc_base = !tag2_r.first ? acc_r :
                    (tag2_r.op == dlfb_pkg::OP_FWD) ? {{12{bias2_r[15]}}, bias2_r, 12'b0} :
                    40'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      emit_r       <= 1'b0;
    end else begin
      tag1_r <= cmd;
      tag2_r <= tag1_r;
      emit_r <= tag2_r.valid && tag2_r.last &&
                (tag2_r.op == dlfb_pkg::OP_FWD || tag2_r.op == dlfb_pkg::OP_BWD);
    end
    prod_r    <= opa * opb;
    waccd2_r  <= waccd_r;
    bias2_r   <= bd_r;
    em_kind_r <= (tag2_r.op == dlfb_pkg::OP_FWD) ? dlfb_pkg::KIND_FWD : dlfb_pkg::KIND_DX;
    em_idx_r  <= tag2_r.idx;
    em_last_r <= tag2_r.lastrun;
    if (tag2_r.valid && (tag2_r.op == dlfb_pkg::OP_FWD || tag2_r.op == dlfb_pkg::OP_BWD)) begin
      acc_r <= acc_base + prod_ext;
    end
  end

  // Gradient read: floor((2v + d) / 2d) is reduced to a floor division by the
  // batch size, worked on the one's complement for negative values.
  logic signed [dlfb_pkg::DIV_W-1:0] dv_n, dv_m;
  logic signed [39:0] dv_v;
  logic [4:0] rem_sh;
  logic       ge;
  logic [3:0] rem_nxt;
  logic [dlfb_pkg::DIV_W-1:0] q_fin, q_res;
  logic       div_load, div_end;

  assign bs = (batch_size == '0) ? dlfb_pkg::BS_W'(1) : batch_size;
  assign div_load = tag1_r.valid &&
                    (tag1_r.op == dlfb_pkg::OP_RDW || tag1_r.op == dlfb_pkg::OP_RDB);

  always_comb begin
    dv_v = tag1_r.zero ? 40'sd0 : (tag1_r.op == dlfb_pkg::OP_RDW) ? waccd_r : baccd_r;
    if (tag1_r.op == dlfb_pkg::OP_RDW) begin
      dv_n = {{2{dv_v[39]}}, dv_v, 1'b0} + {27'b0, bs, 12'b0};
      dv_m = dv_n >>> 13;
    end else begin
      dv_n = {{2{dv_v[39]}}, dv_v, 1'b0} + {39'b0, bs};
      dv_m = dv_n >>> 1;
    end
  end

  assign rem_sh  = {div_rem_r, div_q_r[dlfb_pkg::DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, bs});
  assign rem_nxt = ge ? 4'(rem_sh - {1'b0, bs}) : rem_sh[3:0];
  assign q_fin   = {div_q_r[dlfb_pkg::DIV_W-2:0], ge};
  assign q_res   = div_neg_r ? ~q_fin : q_fin;
  assign div_end = div_run_r && (div_cnt_r == dlfb_pkg::CNT_W'(dlfb_pkg::DIV_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
    end else if (div_load) begin
      div_run_r <= 1'b1;
    end else if (div_end) begin
      div_run_r <= 1'b0;
    end
    if (div_load) begin
      div_neg_r  <= dv_m[dlfb_pkg::DIV_W-1];
      div_q_r    <= dv_m[dlfb_pkg::DIV_W-1] ? ~dv_m : dv_m;
      div_rem_r  <= '0;
      div_cnt_r  <= '0;
      div_kind_r <= (tag1_r.op == dlfb_pkg::OP_RDW) ? dlfb_pkg::KIND_WG : dlfb_pkg::KIND_BG;
      div_idx_r  <= tag1_r.idx;
      div_last_r <= tag1_r.lastrun;
    end else if (div_run_r) begin
      div_q_r   <= q_fin;
      div_rem_r <= rem_nxt;
      div_cnt_r <= div_cnt_r + dlfb_pkg::CNT_W'(1);
    end
  end

  assign sts.div_busy = div_run_r;
  assign sts.div_done = div_end;

  // Result register: rounded accumulator or divider quotient.
  logic signed [39:0] rnd_sum;
  logic signed [dlfb_pkg::DIV_W-1:0] rnd_ext;
  assign rnd_sum = acc_r + 40'sd2048;
  assign rnd_ext = {{15{rnd_sum[39]}}, rnd_sum[39:12]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_r || div_end;
    end
    if (emit_r) begin
      out_kind_r  <= em_kind_r;
      out_index_r <= em_idx_r;
      out_value_r <= dlfb_pkg::sat16(rnd_ext);
      out_last_r  <= em_last_r;
    end else begin
      out_kind_r  <= div_kind_r;
      out_index_r <= div_idx_r;
      out_value_r <= dlfb_pkg::sat16(q_res);
      out_last_r  <= div_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_index        = out_index_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;

endmodule

// ----- rtl/core/dense_layer_forward_backward.sv -----
// Top level of the dense layer: register port, sequencer and datapath.
// Writes and non-final elements do not raise busy. A sample's last forward element holds busy
// while the forward loop runs, one product a cycle, one result per output; a last backward
// element through the backward and weight-gradient loops, one result per input; a gradient
// read through its bit-serial division. Forward and read runs give their last result as busy
// falls; results cannot be stalled. Synchronous active-low reset sets sizes 16, 16, 8.
module dense_layer_forward_backward (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic [2:0]         in_sample,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [3:0]         out_index,
  output logic signed [15:0] out_result_value,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] REG_IN_SIZE  = 2'd0;
  localparam logic [1:0] REG_OUT_SIZE = 2'd1;
  localparam logic [1:0] REG_BATCH    = 2'd2;

  logic [dlfb_pkg::SZ_W-1:0] in_size_r, out_size_r;
  logic [dlfb_pkg::BS_W-1:0] batch_size_r;
  logic cfg_wr;

  dlfb_pkg::dp_cmd_t dp_cmd;
  dlfb_pkg::dp_sts_t dp_sts;

  // The register port completes a write transfer in its access phase;
  // it never waits, so pready is tied high.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_size_r    <= dlfb_pkg::SZ_W'(16);
      out_size_r   <= dlfb_pkg::SZ_W'(16);
      batch_size_r <= dlfb_pkg::BS_W'(8);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IN_SIZE:  in_size_r    <= pwdata[dlfb_pkg::SZ_W-1:0];
        REG_OUT_SIZE: out_size_r   <= pwdata[dlfb_pkg::SZ_W-1:0];
        REG_BATCH:    batch_size_r <= pwdata[dlfb_pkg::BS_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the register contents, zero extended; the unused slot reads zero.
  always_comb begin
    unique case (paddr[3:2])
      REG_IN_SIZE:  prdata = {27'b0, in_size_r};
      REG_OUT_SIZE: prdata = {27'b0, out_size_r};
      REG_BATCH:    prdata = {28'b0, batch_size_r};
      default:      prdata = '0;
    endcase
  end

  // The sequencer decides per accepted transfer which store to write and
  // which product loop, if any, to run.
  dlfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_sample (in_sample),
    .in_size   (in_size_r),
    .out_size  (out_size_r),
    .sts       (dp_sts),
    .busy      (busy),
    .cmd       (dp_cmd)
  );

  // The datapath holds every store, the multiply-accumulate pipeline and the
  // divider used by gradient reads, and drives the result strobe.
  dlfb_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .sts              (dp_sts),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_sample        (in_sample),
    .in_value         (in_value),
    .batch_size       (batch_size_r),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_index        (out_index),
    .out_result_value (out_result_value),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // A gradient read always keeps the block busy until its quotient is out.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == dlfb_pkg::CMD_RD_W || in_cmd == dlfb_pkg::CMD_RD_B))
    |=> busy)
    else $error("gradient read transfer did not raise busy");

  // Gradient read results are single-result runs.
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == dlfb_pkg::KIND_WG || out_kind == dlfb_pkg::KIND_BG))
    |-> out_last)
    else $error("gradient read result without last");

  // The datapath is only fed loop commands while the block reports busy.
  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.valid |-> busy)
    else $error("loop command issued while idle");

  // The divider finishes only while it is running.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    dp_sts.div_done |-> dp_sts.div_busy)
    else $error("divider done without a running division");
`endif

endmodule
